FILE: sv/lrt_pkg.sv
package lrt_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_TRAIN   = 2'd2;
  localparam logic [1:0] OP_PREDICT = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNTRAINED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic CFG_EPOCHS = 1'b0;
  localparam logic CFG_STEP   = 1'b1;

  localparam int NF = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [13:0] my_rating;
    logic [13:0] rival_rating;
    logic [11:0] card_level;
    logic [7:0]  deck_cost_total;
    logic [4:0]  deck_size;
    logic        outcome_won;
  } in_item_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [1:0]  status;
  } out_item_t;

  // record as kept in memory
  typedef struct packed {
    logic        won;
    logic [4:0]  size;
    logic [7:0]  cost;
    logic [11:0] level;
    logic [13:0] rival;
    logic [13:0] mine;
  } record_t;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic [16:0] sig_lut(input logic [5:0] k);
    logic [16:0] v;
    unique case (k)
      6'd0: v = 17'd32768;  6'd1: v = 17'd36843;  6'd2: v = 17'd40793;
      6'd3: v = 17'd44510;  6'd4: v = 17'd47911;  6'd5: v = 17'd50941;
      6'd6: v = 17'd53581;  6'd7: v = 17'd55834;  6'd8: v = 17'd57724;
      6'd9: v = 17'd59287;  6'd10: v = 17'd60565; 6'd11: v = 17'd61598;
      6'd12: v = 17'd62428; 6'd13: v = 17'd63090; 6'd14: v = 17'd63615;
      6'd15: v = 17'd64030; 6'd16: v = 17'd64357; 6'd17: v = 17'd64614;
      6'd18: v = 17'd64816; 6'd19: v = 17'd64974; 6'd20: v = 17'd65097;
      6'd21: v = 17'd65194; 6'd22: v = 17'd65269; 6'd23: v = 17'd65328;
      6'd24: v = 17'd65374; 6'd25: v = 17'd65410; 6'd26: v = 17'd65438;
      6'd27: v = 17'd65459; 6'd28: v = 17'd65476; 6'd29: v = 17'd65489;
      6'd30: v = 17'd65500; 6'd31: v = 17'd65508;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/lrt_div.sv
// unsigned restoring divider, one quotient bit per cycle
module lrt_div (
  input  logic            clk,
  input  logic            rst,
  input  lrt_pkg::div_req_t req,
  output lrt_pkg::div_rsp_t rsp
);
  import lrt_pkg::*;

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        fin;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        den  <= req.divisor;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: fin, quotient: quo};
endmodule

FILE: sv/logistic_regression_trainer.sv
// Four-feature logistic regression trainer with an on-chip record store.
// One command is taken at a time; in_stall stays high until its result beat
// (if any) has been handed over. Clear completes in the idle state, and load
// computes the average deck cost on the shared 64-bit serial divider. Predict
// normalizes four features through that same divider (skipping the division
// when a feature has zero range) and then forms the score with one multiplier.
// Train runs epoch_count passes over record_count records, each record read
// through S_RREAD and S_RDATA and then scored as in predict, and each epoch
// ends with five more divisions for the weight and bias steps. The serial
// divider produces one quotient bit per cycle. The record memory needs no
// clearing pass; only entries below record_count are ever read.
module logistic_regression_trainer #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import lrt_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LDIV   = 5'd1;
  localparam logic [4:0] S_LWAIT  = 5'd2;
  localparam logic [4:0] S_LMINMX = 5'd3;
  localparam logic [4:0] S_TINIT  = 5'd4;
  localparam logic [4:0] S_RREAD  = 5'd5;
  localparam logic [4:0] S_RDATA  = 5'd6;
  localparam logic [4:0] S_CDIV   = 5'd7;
  localparam logic [4:0] S_CWAIT  = 5'd8;
  localparam logic [4:0] S_NDIV   = 5'd9;
  localparam logic [4:0] S_NWAIT  = 5'd10;
  localparam logic [4:0] S_MUL    = 5'd11;
  localparam logic [4:0] S_ACC    = 5'd12;
  localparam logic [4:0] S_SIG    = 5'd13;
  localparam logic [4:0] S_SIG2   = 5'd14;
  localparam logic [4:0] S_GRAD   = 5'd15;
  localparam logic [4:0] S_GACC   = 5'd16;
  localparam logic [4:0] S_UMUL   = 5'd17;
  localparam logic [4:0] S_UDIV   = 5'd18;
  localparam logic [4:0] S_UWAIT  = 5'd19;
  localparam logic [4:0] S_UAPPLY = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;

  logic [4:0] state;

  // configuration
  logic [15:0] epoch_count;
  logic [15:0] learning_step;

  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_count   <= 16'd1000;
      learning_step <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EPOCHS: epoch_count   <= cfg_data;
        CFG_STEP:   learning_step <= cfg_data;
        default:    ;
      endcase
    end
  end

  // model state
  logic [CW-1:0]      record_count;
  logic [15:0]        flo [NF];
  logic [15:0]        fhi [NF];
  logic signed [31:0] wt  [NF];
  logic signed [31:0] bias;
  logic               trained;

  // record memory
  record_t     mem [MAX_RECORDS];
  logic [AW-1:0] rd_addr;
  record_t     rd_rec;
  logic        mem_we;
  record_t     wr_rec;

  always_ff @(posedge clk) begin
    if (mem_we) mem[record_count[AW-1:0]] <= wr_rec;
    rd_rec <= mem[rd_addr];
  end

  // working registers
  in_item_t           cmd;
  record_t            cur;
  logic [15:0]        raw [NF];
  logic [15:0]        feat [NF];
  logic [2:0]         fi;
  logic signed [63:0] score;
  logic signed [63:0] prod;
  logic [16:0]        prob;
  logic signed [17:0] err;
  logic signed [63:0] gw [NF];
  logic signed [63:0] gb;
  logic [CW-1:0]      rec_idx;
  logic [15:0]        epoch;
  logic               neg_q;
  logic [1:0]         ostat;
  logic               train_mode;

  // shared divider
  div_req_t dreq;
  div_rsp_t drsp;

  lrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // sigmoid pieces from the saturated score
  logic signed [31:0] ssat;
  logic [31:0]        smag;
  logic [16:0]        s_lo, s_hi;
  assign ssat = (score > 64'sd2147483647) ? 32'sh7fffffff :
                (score < -64'sd2147483648) ? 32'sh80000000 : score[31:0];
  assign smag = ssat[31] ? (32'd0 - ssat) : ssat;
  assign s_lo = sig_lut({1'b0, smag[26:22]});
  assign s_hi = sig_lut({1'b0, smag[26:22]} + 6'd1);

  // magnitude of signed 64-bit value for the update divisions and the score scaling
  logic [63:0] pmag;
  assign pmag = prod[63] ? (64'd0 - prod) : prod;

  // sat32 of weight or bias minus step
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [63:0] d);
    logic signed [64:0] r;
    r = {a[31], {32{a[31]}}, a} - {d[63], d};
    if (r > 65'sd2147483647) return 32'sh7fffffff;
    if (r < -65'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data.probability = prob[15:0];
  assign out_data.status = ostat;

  logic [15:0] lo_f, hi_f, raw_f;
  assign lo_f  = flo[fi[1:0]];
  assign hi_f  = fhi[fi[1:0]];
  assign raw_f = raw[fi[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      record_count <= '0;
      trained      <= 1'b0;
      bias         <= '0;
      for (int i = 0; i < NF; i++) begin
        flo[i] <= '0;
        fhi[i] <= '0;
        wt[i]  <= '0;
      end
      dreq.start <= 1'b0;
      mem_we     <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      mem_we     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= in_data;
            unique case (in_data.operation)
              OP_CLEAR: begin
                record_count <= '0;
                for (int i = 0; i < NF; i++) begin
                  flo[i] <= '0;
                  fhi[i] <= '0;
                end
              end
              OP_LOAD: begin
                if (record_count < CW'(MAX_RECORDS)) begin
                  cur <= '{won: in_data.outcome_won, size: in_data.deck_size,
                           cost: in_data.deck_cost_total, level: in_data.card_level,
                           rival: in_data.rival_rating, mine: in_data.my_rating};
                  train_mode <= 1'b0;
                  state <= S_CDIV;
                end
              end
              OP_TRAIN: begin
                prob <= '0;
                if (record_count == '0) begin
                  ostat <= ST_EMPTY;
                  state <= S_OUT;
                end else begin
                  ostat <= ST_OK;
                  for (int i = 0; i < NF; i++) wt[i] <= '0;
                  bias  <= '0;
                  epoch <= '0;
                  train_mode <= 1'b1;
                  state <= S_TINIT;
                end
              end
              OP_PREDICT: begin
                if (!trained) begin
                  prob  <= 17'd32768;
                  ostat <= ST_UNTRAINED;
                  state <= S_OUT;
                end else begin
                  ostat <= ST_OK;
                  cur <= '{won: 1'b0, size: in_data.deck_size,
                           cost: in_data.deck_cost_total, level: in_data.card_level,
                           rival: in_data.rival_rating, mine: in_data.my_rating};
                  train_mode <= 1'b0;
                  state <= S_CDIV;
                end
              end
              default: ;
            endcase
          end
        end
        // average deck cost for the current record
        S_CDIV: begin
          raw[0] <= {2'b0, cur.mine};
          raw[1] <= {2'b0, cur.rival};
          raw[2] <= {4'b0, cur.level};
          if (cur.size == 5'd0) begin
            raw[3] <= '0;
            state  <= (cmd.operation == OP_LOAD) ? S_LMINMX : S_NDIV;
            fi     <= '0;
          end else begin
            dreq.start    <= 1'b1;
            dreq.dividend <= {48'd0, cur.cost, 8'd0};
            dreq.divisor  <= {59'd0, cur.size};
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (drsp.done) begin
            raw[3] <= drsp.quotient[15:0];
            fi     <= '0;
            state  <= (cmd.operation == OP_LOAD) ? S_LMINMX : S_NDIV;
          end
        end
        S_LMINMX: begin
          for (int i = 0; i < NF; i++) begin
            if (record_count == '0 || raw[i] < flo[i]) flo[i] <= raw[i];
            if (record_count == '0 || raw[i] > fhi[i]) fhi[i] <= raw[i];
          end
          wr_rec <= cur;
          mem_we <= 1'b1;
          state  <= S_LWAIT;
        end
        S_LWAIT: begin
          record_count <= record_count + CW'(1);
          state <= S_IDLE;
        end
        // normalize feature fi
        S_NDIV: begin
          if (hi_f <= lo_f || raw_f <= lo_f) begin
            feat[fi[1:0]] <= '0;
            if (fi == 3'd3) begin
              fi <= '0;
              score <= {{32{bias[31]}}, bias};
              state <= S_MUL;
            end else fi <= fi + 3'd1;
          end else begin
            dreq.start    <= 1'b1;
            dreq.dividend <= {32'd0, raw_f - lo_f, 16'd0};
            dreq.divisor  <= {48'd0, hi_f - lo_f};
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (drsp.done) begin
            feat[fi[1:0]] <= (drsp.quotient > 64'd65535) ? 16'hffff :
                             drsp.quotient[15:0];
            if (fi == 3'd3) begin
              fi <= '0;
              score <= {{32{bias[31]}}, bias};
              state <= S_MUL;
            end else begin
              fi <= fi + 3'd1;
              state <= S_NDIV;
            end
          end
        end
        // dot product, one multiply per pass
        S_MUL: begin
          prod  <= 64'(wt[fi[1:0]]) * $signed({48'd0, feat[fi[1:0]]});
          state <= S_ACC;
        end
        S_ACC: begin
          // divide by 65536 toward zero
          score <= score + (prod[63] ? -$signed({16'd0, pmag[63:16]}) :
                                       $signed({16'd0, prod[63:16]}));
          if (fi == 3'd3) state <= S_SIG;
          else begin
            fi <= fi + 3'd1;
            state <= S_MUL;
          end
        end
        S_SIG: begin
          prod  <= $signed({47'd0, s_hi - s_lo}) * $signed({42'd0, smag[21:0]});
          neg_q <= ssat[31];
          state <= S_SIG2;
        end
        S_SIG2: begin
          if (smag[31:27] != 5'd0) prob <= neg_q ? 17'd65536 - 17'd65514 : 17'd65514;
          else if (neg_q) prob <= 17'd65536 - (s_lo + prod[38:22]);
          else prob <= s_lo + prod[38:22];
          state <= train_mode ? S_GRAD : S_OUT;
        end
        // gradient accumulation
        S_GRAD: begin
          err   <= $signed({1'b0, prob}) - (cur.won ? 18'sd65536 : 18'sd0);
          fi    <= '0;
          state <= S_GACC;
        end
        S_GACC: begin
          gw[fi[1:0]] <= gw[fi[1:0]] + 64'(err * $signed({1'b0, feat[fi[1:0]]}));
          if (fi == 3'd3) begin
            gb <= gb + 64'(err);
            if (rec_idx + CW'(1) == record_count) begin
              fi <= '0;
              state <= S_UMUL;
            end else begin
              rec_idx <= rec_idx + CW'(1);
              rd_addr <= AW'(rec_idx + CW'(1));
              state <= S_RREAD;
            end
          end else fi <= fi + 3'd1;
        end
        // epoch start
        S_TINIT: begin
          for (int i = 0; i < NF; i++) gw[i] <= '0;
          gb      <= '0;
          rec_idx <= '0;
          rd_addr <= '0;
          state   <= (epoch_count == 16'd0) ? S_LDIV : S_RREAD;
        end
        S_LDIV: begin
          // train finished, its beat carries probability zero
          trained <= 1'b1;
          prob    <= '0;
          state   <= S_OUT;
        end
        S_RREAD: state <= S_RDATA;
        S_RDATA: begin
          cur   <= rd_rec;
          state <= S_CDIV;
        end
        // weight and bias update; fi 4 is the bias
        S_UMUL: begin
          prod  <= 64'($signed({1'b0, learning_step}) *
                   ((fi == 3'd4) ? gb : gw[fi[1:0]]));
          state <= S_UDIV;
        end
        S_UDIV: begin
          neg_q         <= prod[63];
          dreq.start    <= 1'b1;
          dreq.dividend <= pmag;
          dreq.divisor  <= (fi == 3'd4) ? 64'(record_count) << 8
                                        : 64'(record_count) << 24;
          state <= S_UWAIT;
        end
        S_UWAIT: if (drsp.done) begin
          prod  <= neg_q ? -$signed(drsp.quotient) : $signed(drsp.quotient);
          state <= S_UAPPLY;
        end
        S_UAPPLY: begin
          if (fi == 3'd4) begin
            bias <= sub_sat(bias, prod);
            if (epoch + 16'd1 == epoch_count) state <= S_LDIV;
            else begin
              epoch <= epoch + 16'd1;
              state <= S_TINIT;
            end
          end else begin
            wt[fi[1:0]] <= sub_sat(wt[fi[1:0]], prod);
            fi    <= fi + 3'd1;
            state <= S_UMUL;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/lrt_checker.sv
module lrt_assert (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input lrt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lrt_pkg::out_item_t out_data
);
  import lrt_pkg::*;

  // a pending result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no command taken while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // status stays in its legal codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_UNTRAINED ||
                   out_data.status == ST_EMPTY))
    else $error("bad status");

  // untrained default carries one half
  a_default: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_UNTRAINED |-> out_data.probability == 16'd32768)
    else $error("bad untrained default");
endmodule

bind logistic_regression_trainer lrt_assert u_lrt_assert (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/lrt_checker.sv
`timescale 1ns / 100ps

module lrt_checker
  import lrt_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        outstanding
);

  localparam int SIG_PTS [0:32] = '{
    32768, 36843, 40793, 44510, 47911, 50941, 53581, 55834,
    57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
    64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
    65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
    65514};

  typedef logic [NF-1:0][31:0] feat_t;

  record_t     rec_mem [STORE_DEPTH];
  int unsigned rec_total;
  int unsigned lo_bound [NF];
  int unsigned hi_bound [NF];
  int          weight [NF];
  int          bias;
  bit          trained;
  int unsigned epochs;
  int unsigned rate;
  out_item_t   result_q [$];

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic feat_t raw_of(record_t r);
    feat_t raw;
    raw[0] = 32'(r.mine);
    raw[1] = 32'(r.rival);
    raw[2] = 32'(r.level);
    raw[3] = (r.size != 0) ? (32'(r.cost) << 8) / 32'(r.size) : 32'd0;
    return raw;
  endfunction

  // min-max scaling to q0.16
  function automatic feat_t scaled(record_t r);
    feat_t raw, f;
    logic [63:0] q;
    raw = raw_of(r);
    for (int i = 0; i < NF; i++) begin
      if (hi_bound[i] <= lo_bound[i] || raw[i] <= lo_bound[i]) begin
        f[i] = 0;
      end else begin
        q = (64'(raw[i] - lo_bound[i]) << 16) / 64'(hi_bound[i] - lo_bound[i]);
        f[i] = (q > 64'd65535) ? 32'd65535 : q[31:0];
      end
    end
    return f;
  endfunction

  function automatic int score(feat_t f);
    longint s;
    s = longint'(bias);
    for (int i = 0; i < NF; i++)
      s += (longint'(weight[i]) * longint'(f[i])) / 64'sd65536;
    return clamp32(s);
  endfunction

  // table sigmoid with linear interpolation, mirrored for negative scores
  function automatic int squash(int s);
    logic [31:0] a;
    int idx, v;
    a = (s < 0) ? -s : s;
    idx = int'(a >> 22);
    if (idx >= 32) begin
      v = SIG_PTS[32];
    end else begin
      v = SIG_PTS[idx] + int'((longint'(SIG_PTS[idx+1] - SIG_PTS[idx]) *
                              longint'(a[21:0])) >>> 22);
    end
    return (s < 0) ? 65536 - v : v;
  endfunction

  function automatic void run_training();
    longint gw [NF];
    longint gb, err, n;
    feat_t f;
    n = longint'(rec_total);
    for (int i = 0; i < NF; i++) weight[i] = 0;
    bias = 0;
    for (int unsigned e = 0; e < epochs; e++) begin
      for (int i = 0; i < NF; i++) gw[i] = 0;
      gb = 0;
      for (int unsigned k = 0; k < rec_total; k++) begin
        f = scaled(rec_mem[k]);
        err = longint'(squash(score(f))) - (rec_mem[k].won ? 64'sd65536 : 64'sd0);
        for (int i = 0; i < NF; i++) gw[i] += err * longint'(f[i]);
        gb += err;
      end
      for (int i = 0; i < NF; i++)
        weight[i] = clamp32(longint'(weight[i]) - (longint'(rate) * gw[i]) / (n << 24));
      bias = clamp32(longint'(bias) - (longint'(rate) * gb) / (n << 8));
    end
    trained = 1;
  endfunction

  function automatic void take_command(in_item_t it);
    record_t r;
    feat_t raw;
    out_item_t res;
    r = '{won: it.outcome_won, size: it.deck_size, cost: it.deck_cost_total,
          level: it.card_level, rival: it.rival_rating, mine: it.my_rating};
    case (it.operation)
      OP_CLEAR: begin
        rec_total = 0;
        for (int i = 0; i < NF; i++) begin
          lo_bound[i] = 0;
          hi_bound[i] = 0;
        end
      end
      OP_LOAD: begin
        if (rec_total < STORE_DEPTH) begin
          raw = raw_of(r);
          for (int i = 0; i < NF; i++) begin
            if (rec_total == 0 || raw[i] < lo_bound[i]) lo_bound[i] = raw[i];
            if (rec_total == 0 || raw[i] > hi_bound[i]) hi_bound[i] = raw[i];
          end
          rec_mem[rec_total] = r;
          rec_total++;
        end
      end
      OP_TRAIN: begin
        res.probability = '0;
        if (rec_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          run_training();
          res.status = ST_OK;
        end
        result_q.push_back(res);
      end
      default: begin
        if (!trained) begin
          res.probability = 16'd32768;
          res.status = ST_UNTRAINED;
        end else begin
          r.won = 1'b0;
          res.probability = 16'(squash(score(scaled(r))));
          res.status = ST_OK;
        end
        result_q.push_back(res);
      end
    endcase
  endfunction

  task automatic report(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rec_total = 0;
      for (int i = 0; i < NF; i++) begin
        lo_bound[i] = 0;
        hi_bound[i] = 0;
        weight[i] = 0;
      end
      bias = 0;
      trained = 0;
      epochs = 1000;
      rate = 655;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EPOCHS: epochs = 32'(cfg_data);
          CFG_STEP:   rate = 32'(cfg_data);
        endcase
      end
      if (in_valid && !in_stall) take_command(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report("unexpected result beat, probability", -1, int'(out_data.probability));
        end else begin
          want = result_q.pop_front();
          if (out_data.probability != want.probability)
            report("probability", int'(want.probability), int'(out_data.probability));
          if (out_data.status != want.status)
            report("status", int'(want.status), int'(out_data.status));
        end
      end
    end
    outstanding <= result_q.size();
  end

endmodule

FILE: sim/tb_logistic_regression_trainer.sv
`timescale 1ns / 100ps

module tb_logistic_regression_trainer;
  import lrt_pkg::*;

  // longest quiet stretch is one small training run; this leaves ample margin
  localparam int QUIET_LIMIT = 200000;
  // a load can still be dividing after the last result beat has gone
  localparam int SETTLE_CYCLES = 200;
  localparam int SMALL_SET = 12;
  // a smaller store keeps the fill test short
  localparam int DEPTH = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_EPOCHS;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;
  int loaded = 0;
  bit steady = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  logistic_regression_trainer #(.MAX_RECORDS(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lrt_checker #(.STORE_DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side: stall pattern that changes character now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op);
    in_item_t it;
    it.operation = op;
    it.my_rating = 14'($urandom_range(0, 16383));
    it.rival_rating = 14'($urandom_range(0, 16383));
    it.card_level = 12'($urandom_range(0, 4095));
    it.deck_cost_total = 8'($urandom_range(0, 255));
    // sizes above 16 are legal field values too
    it.deck_size = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 16));
    // mostly a learnable label: the higher rating tends to win
    if ($urandom_range(0, 4) == 0) it.outcome_won = 1'($urandom_range(0, 1));
    else it.outcome_won = (it.my_rating > it.rival_rating);
    return it;
  endfunction

  // one command beat; outside steady phases the sender runs in bursts
  task automatic send(in_item_t it);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (it.operation == OP_CLEAR) loaded = 0;
    else if (it.operation == OP_LOAD && loaded < DEPTH) loaded++;
  endtask

  // hold the sender until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int n, pick;
    logic [15:0] step_val;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: untrained predict and empty train under the largest epoch count
    write_reg(CFG_EPOCHS, 16'hffff);
    write_reg(CFG_STEP, 16'd1);
    send(make_item(OP_PREDICT));
    send(make_item(OP_TRAIN));
    it = '1;
    it.operation = OP_LOAD;
    send(it);
    it = '0;
    it.operation = OP_LOAD;
    send(it);
    it = make_item(OP_LOAD);
    it.deck_size = 5'd16;
    send(it);
    send(make_item(OP_PREDICT));
    drain();
    write_reg(CFG_EPOCHS, 16'd1);
    send(make_item(OP_TRAIN));
    it = '1;
    it.operation = OP_PREDICT;
    send(it);
    it = '0;
    it.operation = OP_PREDICT;
    send(it);
    send(make_item(OP_CLEAR));
    // trained, but bounds are back at zero
    send(make_item(OP_PREDICT));
    // identical records give zero range on every feature
    it = make_item(OP_LOAD);
    send(it);
    send(it);
    send(make_item(OP_TRAIN));
    send(it);
    it.operation = OP_PREDICT;
    send(it);
    drain();
    write_reg(CFG_STEP, 16'hffff);
    write_reg(CFG_EPOCHS, 16'd3);
    for (int i = 0; i < 4; i++) send(make_item(OP_LOAD));
    send(make_item(OP_TRAIN));
    it = '1;
    it.operation = OP_PREDICT;
    send(it);
    send(make_item(OP_PREDICT));

    // fill the store and push past it, then predict with the old weights
    drain();
    steady = 1;
    send(make_item(OP_CLEAR));
    for (int i = 0; i < DEPTH + 2; i++) send(make_item(OP_LOAD));
    for (int i = 0; i < 4; i++) send(make_item(OP_PREDICT));
    send(make_item(OP_CLEAR));

    // random phases: small record sets, short training, many predictions
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      steady = (ph % 3 == 0);
      pick = $urandom_range(0, 2);
      step_val = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hffff : 16'($urandom_range(1, 65535));
      write_reg(CFG_STEP, step_val);
      write_reg(CFG_EPOCHS, ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(2, 6)));
      send(make_item(OP_CLEAR));
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send(make_item(OP_LOAD));
      send(make_item(OP_TRAIN));
      for (int i = 0; i < 45; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send(make_item(OP_PREDICT));
        else if (pick < 92) send(make_item(loaded < SMALL_SET ? OP_LOAD : OP_PREDICT));
        else if (pick < 97) send(make_item(OP_CLEAR));
        else send(make_item(OP_TRAIN));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
